@@ sv/saff_pkg.sv @@
// Package: shared constants and types of the short-address frame filter.
`default_nettype none

package saff_pkg;

  localparam int unsigned CNT_W_DEF = 32;
  localparam int unsigned CNT_OUT_W = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAN_ID      = 2'd0,
    REG_MIN_PAYLOAD = 2'd1,
    REG_NODE_OFFSET = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] PAN_ID_RST      = 16'h5254;
  localparam logic [7:0]  MIN_PAYLOAD_RST = 8'd16;
  localparam logic [7:0]  NODE_OFFSET_RST = 8'd0;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned FCS_BYTES = 2;

  // byte positions in a frame; position 0 is the length byte
  localparam logic [7:0] POS_LEN    = 8'd0;
  localparam logic [7:0] POS_FCF0   = 8'd1;
  localparam logic [7:0] POS_FCF1   = 8'd2;
  localparam logic [7:0] POS_PAN_LO = 8'd4;
  localparam logic [7:0] POS_PAN_HI = 8'd5;
  localparam logic [7:0] POS_DST_LO = 8'd6;
  localparam logic [7:0] POS_DST_HI = 8'd7;
  localparam logic [7:0] POS_SRC_LO = 8'd8;
  localparam logic [7:0] POS_MAX    = 8'd255;

  localparam logic [2:0] FRAME_TYPE_DATA = 3'h1;
  localparam int unsigned PANC_BIT       = 6;
  localparam logic [1:0] ADDR_MODE_SHORT = 2'h2;
  localparam logic [7:0] BCAST_BYTE      = 8'hFF;

endpackage

`default_nettype wire

@@ sv/saff_in_if.sv @@
// Interface: received byte channel.
`default_nettype none

interface saff_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        rx_byte;
  logic              last_byte;
  logic signed [7:0] rssi;
  logic [7:0]        lqi;

  modport source (output valid, output rx_byte, output last_byte, output rssi, output lqi,
                  input ready);
  modport sink (input valid, input rx_byte, input last_byte, input rssi, input lqi,
                output ready);
endinterface

`default_nettype wire

@@ sv/saff_out_if.sv @@
// Interface: frame verdict channel.
`default_nettype none

interface saff_out_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [7:0]        payload_len;
  logic signed [7:0] link_rssi;
  logic [7:0]        link_quality;
  logic [31:0]       seen_count;
  logic [31:0]       ours_count;

  modport source (output valid, output accepted, output payload_len, output link_rssi,
                  output link_quality, output seen_count, output ours_count,
                  input ready);
  modport sink (input valid, input accepted, input payload_len, input link_rssi,
                input link_quality, input seen_count, input ours_count,
                output ready);
endinterface

`default_nettype wire

@@ sv/saff_cfg_if.sv @@
// Interface: configuration register write channel.
`default_nettype none

interface saff_cfg_if;
  import saff_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/short_addr_frame_filter_unit.sv @@
// Top level: short-address 802.15.4 receive frame filter.
//
// in_if carries received frames one byte per item; the first byte of a frame
// is the PSDU length and last_byte marks the final byte. One item is taken
// per cycle unless a last byte waits on a busy verdict register. Each item
// goes into an input register and is checked in the next cycle against the
// header state; only an item with last_byte set makes a verdict item on
// out_if, raising out_if.valid once it reaches the verdict register. Without
// such a wait, throughput is 1 byte per cycle (single header-check stage).
// The verdict register frees up in the cycle its item is taken, so a stalled
// receiver holds out_if and backs up into the input register and then in_if;
// bytes that carry no verdict keep flowing while the verdict waits.
// cfg_if is always ready; registers are pan_id, min_payload_len, node_offset,
// to be written between frames while nothing is in flight.
// Reset (rst_n low, synchronous) empties both registers, clears both frame
// counters, restarts frame parsing and restores the register defaults.
`default_nettype none

module short_addr_frame_filter_unit #(
  parameter int unsigned COUNTER_WIDTH = saff_pkg::CNT_W_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  saff_in_if.sink   in_if,
  saff_out_if.source out_if,
  saff_cfg_if.sink  cfg_if
);
  import saff_pkg::*;

  // configuration
  logic [15:0] pan_r;
  logic [7:0]  min_pay_r;
  logic [7:0]  node_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r      <= PAN_ID_RST;
      min_pay_r  <= MIN_PAYLOAD_RST;
      node_off_r <= NODE_OFFSET_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_PAN_ID:      pan_r      <= cfg_if.data;
        REG_MIN_PAYLOAD: min_pay_r  <= cfg_if.data[7:0];
        REG_NODE_OFFSET: node_off_r <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // input register
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic signed [7:0] s1_rssi_r;
  logic [7:0]        s1_lqi_r;

  logic out_valid_r;
  logic out_free;
  logic s2_fire;
  logic in_fire;

  assign out_free     = !out_valid_r || out_if.ready;
  assign s2_fire      = s1_valid_r && (!s1_last_r || out_free);
  assign in_if.ready  = !s1_valid_r || s2_fire;
  assign in_fire      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.rx_byte;
      s1_last_r <= in_if.last_byte;
      s1_rssi_r <= in_if.rssi;
      s1_lqi_r  <= in_if.lqi;
    end
  end

  // frame state
  logic [7:0]               pos_r,  pos_nxt;
  logic [7:0]               decl_r, decl_nxt;
  logic                     hg_r,   hg_nxt;
  logic [7:0]               src_r,  src_nxt;
  logic                     im_r,   im_nxt;
  logic [COUNTER_WIDTH-1:0] seen_r, seen_nxt;
  logic [COUNTER_WIDTH-1:0] ours_r, ours_nxt;

  logic [7:0] decl_eff;
  logic       byte_ok;
  logic       hg_new;
  logic       im_new;
  logic       src_new;
  logic [8:0] node_pos;
  logic [9:0] node_end;
  logic [8:0] len_min;
  logic       frame_ok;
  logic [7:0] pay_len;

  always_comb begin
    byte_ok = 1'b1;
    case (pos_r) inside
      POS_FCF0:   byte_ok = (s1_byte_r[2:0] == FRAME_TYPE_DATA) && s1_byte_r[PANC_BIT];
      POS_FCF1:   byte_ok = (s1_byte_r[3:2] == ADDR_MODE_SHORT) &&
                            (s1_byte_r[7:6] == ADDR_MODE_SHORT);
      POS_PAN_LO: byte_ok = (s1_byte_r == pan_r[7:0]);
      POS_PAN_HI: byte_ok = (s1_byte_r == pan_r[15:8]);
      POS_DST_LO, POS_DST_HI: byte_ok = (s1_byte_r == BCAST_BYTE);
      default:    byte_ok = 1'b1;
    endcase
  end

  assign node_pos = 9'(HDR_BYTES + 1) + {1'b0, node_off_r};
  assign node_end = {1'b0, node_pos} + 10'(FCS_BYTES);
  assign len_min  = 9'(HDR_BYTES + FCS_BYTES) + {1'b0, min_pay_r};

  assign decl_eff = (pos_r == POS_LEN) ? s1_byte_r : decl_r;
  assign hg_new   = hg_r && byte_ok;
  assign src_new  = ({1'b0, pos_r} == node_pos);
  assign im_new   = src_new ? (s1_byte_r == src_r) : im_r;

  assign frame_ok = hg_new && im_new && ({1'b0, decl_eff} >= len_min) &&
                    (node_end <= {2'b00, decl_eff});
  assign pay_len  = frame_ok ? (decl_eff - 8'(HDR_BYTES + FCS_BYTES)) : 8'd0;

  always_comb begin
    pos_nxt  = (pos_r == POS_MAX) ? pos_r : pos_r + 8'd1;
    decl_nxt = decl_eff;
    hg_nxt   = hg_new;
    src_nxt  = (pos_r == POS_SRC_LO) ? s1_byte_r : src_r;
    im_nxt   = im_new;
    seen_nxt = seen_r;
    ours_nxt = ours_r;
    if (s1_last_r) begin
      pos_nxt  = POS_LEN;
      decl_nxt = 8'd0;
      hg_nxt   = 1'b1;
      src_nxt  = 8'd0;
      im_nxt   = 1'b0;
      seen_nxt = seen_r + COUNTER_WIDTH'(1);
      if (frame_ok) begin
        ours_nxt = ours_r + COUNTER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_LEN;
      decl_r <= 8'd0;
      hg_r   <= 1'b1;
      src_r  <= 8'd0;
      im_r   <= 1'b0;
      seen_r <= '0;
      ours_r <= '0;
    end else if (s2_fire) begin
      pos_r  <= pos_nxt;
      decl_r <= decl_nxt;
      hg_r   <= hg_nxt;
      src_r  <= src_nxt;
      im_r   <= im_nxt;
      seen_r <= seen_nxt;
      ours_r <= ours_nxt;
    end
  end

  // verdict register
  logic              acc_r;
  logic [7:0]        pay_len_r;
  logic signed [7:0] rssi_r;
  logic [7:0]        lqi_r;
  logic [31:0]       seen_out_r;
  logic [31:0]       ours_out_r;
  logic              verdict_load;

  assign verdict_load = s2_fire && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (verdict_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict_load) begin
      acc_r      <= frame_ok;
      pay_len_r  <= pay_len;
      rssi_r     <= s1_rssi_r;
      lqi_r      <= s1_lqi_r;
      seen_out_r <= CNT_OUT_W'(seen_nxt);
      ours_out_r <= CNT_OUT_W'(ours_nxt);
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.accepted     = acc_r;
  assign out_if.payload_len  = pay_len_r;
  assign out_if.link_rssi    = rssi_r;
  assign out_if.link_quality = lqi_r;
  assign out_if.seen_count   = seen_out_r;
  assign out_if.ours_count   = ours_out_r;

`ifndef SYNTH
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_load |=> out_valid_r)
    else $error("last byte did not load a verdict");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_load |=> (pos_r == POS_LEN) && hg_r && !im_r)
    else $error("frame state not restarted after last byte");

  a_count_on_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !s1_last_r) |=> ($stable(seen_r) && $stable(ours_r)))
    else $error("frame counter moved inside a frame");

  a_ours_le_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_load && !frame_ok |=> $stable(ours_r))
    else $error("rejected frame counted as ours");
`endif

endmodule

`default_nettype wire

@@ tb/tb_short_addr_frame_filter_unit.sv @@
// Testbench: directed and random received-frame checks of the short-address frame filter.
`timescale 1ns / 1ps

module tb_short_addr_frame_filter_unit;
  import saff_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic [7:0] rssi;
    logic [7:0] lqi;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  payload_len;
    logic [7:0]  link_rssi;
    logic [7:0]  link_quality;
    logic [31:0] seen_count;
    logic [31:0] ours_count;
  } verdict_t;

  typedef struct packed {
    item_t    it;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_QUARTER, RDY_PERIODIC} stall_mode_t;

  logic clk;
  logic rst_n;

  saff_in_if  in_if();
  saff_out_if out_if();
  saff_cfg_if cfg_if();

  short_addr_frame_filter_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // filter model state and register copies
  logic [15:0] cfg_pan;
  logic [7:0]  cfg_min;
  logic [7:0]  cfg_off;
  logic [7:0]  cur_pos;
  logic [7:0]  len_decl;
  logic        hdr_ok;
  logic [7:0]  src_id;
  logic        node_hit;
  logic [31:0] n_seen;
  logic [31:0] n_ours;

  verdict_t    verdicts_due[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  frame_q[$];

  int          n_errors;
  int          n_items;
  int          n_frames;
  int          n_checked;
  int          n_accepted;
  int          cycle_cnt;
  int          burst_left;
  bit          idle_on;
  stall_mode_t stall_mode;
  int          stall_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
               verdicts_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_cnt  <= 127;
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      RDY_ALWAYS:  out_if.ready <= 1'b1;
      RDY_HALF:    out_if.ready <= 1'($urandom_range(0, 1));
      RDY_QUARTER: out_if.ready <= ($urandom_range(0, 3) == 0);
      default:     out_if.ready <= (cycle_cnt[3:0] < 4'd9);
    endcase
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.accepted     = out_if.accepted;
      got.payload_len  = out_if.payload_len;
      got.link_rssi    = out_if.link_rssi;
      got.link_quality = out_if.link_quality;
      got.seen_count   = out_if.seen_count;
      got.ours_count   = out_if.ours_count;
      if (verdicts_due.size() == 0) begin
        if (n_errors < 10) $display("unexpected verdict item at cycle %0d", cycle_cnt);
        n_errors++;
      end else begin
        want = verdicts_due.pop_front();
        n_checked++;
        if (got.accepted) n_accepted++;
        if (got !== want) begin
          if (n_errors < 10) begin
            $display("mismatch at cycle %0d: exp acc=%0d len=%0d rssi=%0d lqi=%0d",
                     cycle_cnt, want.accepted, want.payload_len, $signed(want.link_rssi),
                     want.link_quality);
            $display("  exp seen=%0d ours=%0d", want.seen_count, want.ours_count);
            $display("  got acc=%0d len=%0d rssi=%0d lqi=%0d seen=%0d ours=%0d",
                     got.accepted, got.payload_len, $signed(got.link_rssi),
                     got.link_quality, got.seen_count, got.ours_count);
          end
          n_errors++;
        end
      end
    end
  end

  task automatic filter_byte(input item_t it, output bit has_v, output verdict_t v);
    int npos;
    int need;
    bit ok;
    npos = int'(HDR_BYTES) + 1 + int'(cfg_off);
    need = int'(HDR_BYTES) + int'(FCS_BYTES) + int'(cfg_min);
    has_v = 1'b0;
    v = '0;
    if (cur_pos == POS_LEN) begin
      len_decl = it.rx_byte;
    end else begin
      case (cur_pos)
        POS_FCF0: if (it.rx_byte[2:0] != FRAME_TYPE_DATA || !it.rx_byte[PANC_BIT]) hdr_ok = 1'b0;
        POS_FCF1: begin
          if (it.rx_byte[3:2] != ADDR_MODE_SHORT || it.rx_byte[7:6] != ADDR_MODE_SHORT)
            hdr_ok = 1'b0;
        end
        POS_PAN_LO: if (it.rx_byte != cfg_pan[7:0]) hdr_ok = 1'b0;
        POS_PAN_HI: if (it.rx_byte != cfg_pan[15:8]) hdr_ok = 1'b0;
        POS_DST_LO, POS_DST_HI: if (it.rx_byte != BCAST_BYTE) hdr_ok = 1'b0;
        POS_SRC_LO: src_id = it.rx_byte;
        default: ;
      endcase
      if (int'(cur_pos) == npos) node_hit = (it.rx_byte == src_id);
    end
    if (cur_pos != POS_MAX) cur_pos = cur_pos + 8'd1;
    if (it.last_byte) begin
      ok = hdr_ok && node_hit && int'(len_decl) >= need
           && npos + int'(FCS_BYTES) <= int'(len_decl);
      n_seen = n_seen + 32'd1;
      if (ok) n_ours = n_ours + 32'd1;
      v.accepted     = ok;
      v.payload_len  = ok ? 8'(int'(len_decl) - int'(HDR_BYTES) - int'(FCS_BYTES)) : 8'h00;
      v.link_rssi    = it.rssi;
      v.link_quality = it.lqi;
      v.seen_count   = n_seen;
      v.ours_count   = n_ours;
      has_v = 1'b1;
      cur_pos  = POS_LEN;
      len_decl = 8'h00;
      hdr_ok   = 1'b1;
      src_id   = 8'h00;
      node_hit = 1'b0;
    end
  endtask

  task automatic push_byte(input item_t it, input bit typed = 1'b0, input verdict_t tv = '0);
    bit has_v;
    verdict_t v;
    int g;
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= it.rx_byte;
    in_if.last_byte <= it.last_byte;
    in_if.rssi      <= it.rssi;
    in_if.lqi       <= it.lqi;
    do @(posedge clk); while (!in_if.ready);
    filter_byte(it, has_v, v);
    if (has_v) verdicts_due.push_back(typed ? tv : v);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      g = idle_on ? int'($urandom_range(1, 6)) : 0;
      if (g > 0) begin
        in_if.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_PAN_ID:      cfg_pan = val;
      REG_MIN_PAYLOAD: cfg_min = val[7:0];
      REG_NODE_OFFSET: cfg_off = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] pan, input logic [7:0] minp, input logic [7:0] off);
    write_reg(REG_PAN_ID, pan);
    write_reg(REG_MIN_PAYLOAD, {8'h00, minp});
    write_reg(REG_NODE_OFFSET, {8'h00, off});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic dir_row_t tab_row(input logic [7:0] b, input logic last,
                                       input logic [7:0] rs, input logic [7:0] lq,
                                       input logic typed = 1'b0, input logic acc = 1'b0,
                                       input logic [7:0] plen = 8'h00,
                                       input logic [31:0] seen = 32'd0,
                                       input logic [31:0] ours = 32'd0);
    dir_row_t r;
    r.it    = '{rx_byte: b, last_byte: last, rssi: rs, lqi: lq};
    r.typed = typed;
    r.v     = '{accepted: acc, payload_len: plen, link_rssi: rs, link_quality: lq,
                seen_count: seen, ours_count: ours};
    return r;
  endfunction

  // mostly well-formed frames for the current registers, some damaged, some noise
  task automatic build_frame();
    int npos;
    int l0;
    int decl;
    int r;
    int k;
    logic [7:0] src;
    frame_q.delete();
    npos = int'(HDR_BYTES) + 1 + int'(cfg_off);
    l0 = int'(HDR_BYTES) + int'(FCS_BYTES) + int'(cfg_min);
    if (npos + int'(FCS_BYTES) > l0) l0 = npos + int'(FCS_BYTES);
    if (l0 > 255) l0 = 255;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      k = $urandom_range(1, 30);
      repeat (k) frame_q.push_back(8'($urandom));
      return;
    end
    decl = l0 + int'($urandom_range(0, 6));
    if ($urandom_range(0, 19) == 0) decl = $urandom_range(l0, 255);
    if (decl > 255) decl = 255;
    src = 8'($urandom);
    frame_q.push_back(8'(decl));
    frame_q.push_back((8'($urandom) & 8'hB8) | 8'h41);
    frame_q.push_back((8'($urandom) & 8'h33) | 8'h88);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(cfg_pan[7:0]);
    frame_q.push_back(cfg_pan[15:8]);
    frame_q.push_back(BCAST_BYTE);
    frame_q.push_back(BCAST_BYTE);
    frame_q.push_back(src);
    frame_q.push_back(8'($urandom));
    while (frame_q.size() <= decl) frame_q.push_back(8'($urandom));
    frame_q[npos] = src;
    if (r >= 60 && r < 70) begin
      k = $urandom_range(1, 7);
      frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
    end else if (r >= 70 && r < 78) begin
      frame_q[npos] = frame_q[npos] ^ 8'($urandom_range(1, 255));
    end else if (r >= 78 && r < 86) begin
      k = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > k) void'(frame_q.pop_back());
    end else if (r >= 86) begin
      frame_q[0] = 8'($urandom);
    end
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(1, 4);
      repeat (k) frame_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 49) == 0) repeat (260) frame_q.push_back(8'($urandom));
  endtask

  task automatic send_frame();
    item_t it;
    for (int i = 0; i < frame_q.size(); i++) begin
      it.rx_byte   = frame_q[i];
      it.last_byte = (i == frame_q.size() - 1);
      it.rssi      = 8'($urandom);
      it.lqi       = 8'($urandom);
      push_byte(it);
    end
    n_frames++;
  endtask

  task automatic run_phase(input logic [15:0] pan, input logic [7:0] minp,
                           input logic [7:0] off, input int budget);
    int start;
    int nfr;
    drain_verdicts();
    set_config(pan, minp, off);
    idle_on = ($urandom_range(0, 3) != 0);
    start = n_items;
    nfr = 0;
    while (n_items - start < budget) begin
      build_frame();
      send_frame();
      nfr++;
      if (nfr == 3) drain_verdicts();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    in_if.last_byte = 1'b0;
    in_if.rssi = 8'sd0;
    in_if.lqi = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PAN_ID;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    cfg_pan = PAN_ID_RST;
    cfg_min = MIN_PAYLOAD_RST;
    cfg_off = NODE_OFFSET_RST;
    cur_pos = POS_LEN;
    len_decl = 8'h00;
    hdr_ok = 1'b1;
    src_id = 8'h00;
    node_hit = 1'b0;
    n_seen = '0;
    n_ours = '0;
    n_errors = 0;
    n_items = 0;
    n_frames = 0;
    n_checked = 0;
    n_accepted = 0;
    cycle_cnt = 0;
    burst_left = 0;
    idle_on = 1'b0;
    stall_mode = RDY_ALWAYS;
    stall_cnt = 0;

    // length-byte-only frames at the field extremes
    dir_tab.push_back(tab_row(8'h00, 1'b1, 8'h80, 8'h00, 1'b1, 1'b0, 8'd0, 32'd1, 32'd0));
    dir_tab.push_back(tab_row(8'hFF, 1'b1, 8'h7F, 8'hFF, 1'b1, 1'b0, 8'd0, 32'd2, 32'd0));
    // smallest frame that passes with no payload minimum
    dir_tab.push_back(tab_row(8'h0C, 1'b0, 8'h80, 8'hFF));
    dir_tab.push_back(tab_row(8'h41, 1'b0, 8'h7F, 8'h00));
    dir_tab.push_back(tab_row(8'h88, 1'b0, 8'h00, 8'h01));
    dir_tab.push_back(tab_row(8'h00, 1'b0, 8'h01, 8'h80));
    dir_tab.push_back(tab_row(8'h54, 1'b0, 8'hFF, 8'h7F));
    dir_tab.push_back(tab_row(8'h52, 1'b0, 8'h55, 8'hAA));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 8'hAA, 8'h55));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 8'h12, 8'h34));
    dir_tab.push_back(tab_row(8'h33, 1'b0, 8'h56, 8'h78));
    dir_tab.push_back(tab_row(8'h00, 1'b0, 8'h9A, 8'hBC));
    dir_tab.push_back(tab_row(8'h33, 1'b1, 8'h10, 8'h40, 1'b1, 1'b1, 8'd1, 32'd3, 32'd1));
    // frame that ends right after its first header byte
    dir_tab.push_back(tab_row(8'h0C, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h41, 1'b1, 8'hF0, 8'h0F));
    // node byte falls into the FCS of the declared length
    dir_tab.push_back(tab_row(8'h0B, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h41, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h88, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h07, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h54, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h52, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h5A, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h01, 1'b0, 8'h00, 8'h00));
    dir_tab.push_back(tab_row(8'h5A, 1'b1, 8'hC3, 8'h3C));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(PAN_ID_RST, 8'd0, 8'd0);
    foreach (dir_tab[i]) push_byte(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].v);

    run_phase(PAN_ID_RST, MIN_PAYLOAD_RST, NODE_OFFSET_RST, 180);
    run_phase(16'h0000, 8'd0, 8'd0, 180);
    run_phase(16'hFFFF, 8'd0, 8'd5, 180);
    run_phase(16'($urandom), 8'($urandom_range(0, 24)), 8'($urandom_range(0, 12)), 180);
    run_phase(16'($urandom), 8'd244, 8'd0, 150);
    run_phase(16'($urandom), 8'd0, 8'd243, 150);
    run_phase(16'($urandom), 8'd255, 8'($urandom_range(0, 3)), 150);
    run_phase(16'($urandom), 8'd3, 8'd1, 180);

    drain_verdicts();
    repeat (8) @(posedge clk);

    if (verdicts_due.size() != 0) begin
      $display("%0d verdicts never arrived", verdicts_due.size());
      n_errors++;
    end
    $display("sent %0d bytes in %0d frames over 9 register settings,", n_items, n_frames);
    $display("incl. length and offset limits; checked %0d verdicts, %0d accepted, %0d mismatches",
             n_checked, n_accepted, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
